// ===== hdl/cau_pkg.sv =====
// Package: shared constants, opcodes and types of the complex arithmetic unit.
package cau_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 2 * DataW;       // one signed product
  localparam int unsigned SumW     = ProdW + 1;       // sum of two products
  localparam int unsigned QuotW    = DataW + 1;       // quotient incl. guard bit
  localparam int unsigned DivSteps = SumW + FracBits; // restoring divider steps

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef struct packed {
    logic                   neg;
    logic [SumW-1:0]        mag;
  } smag_t;

  // Saturate a sign/magnitude value into a signed 32-bit word.
  function automatic logic [DataW:0] sat_mag(input logic neg, input logic [SumW-1:0] mag);
    logic [DataW:0] r;
    if (!neg) begin
      if (mag > SumW'(32'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
      else                             r = {1'b0, mag[DataW-1:0]};
    end else begin
      if (mag > SumW'(33'h0_8000_0000)) r = {1'b1, 32'h8000_0000};
      else                               r = {1'b0, DataW'(~mag[DataW-1:0] + 1'b1)};
    end
    return r;
  endfunction

endpackage

// ===== hdl/cau_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, truncating.
module cau_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [cau_pkg::SumW-1:0] num_i,
  input  logic [cau_pkg::SumW-1:0] den_i,
  output logic                 valid_o,
  output logic [cau_pkg::QuotW-1:0] quot_o,   // low quotient bits, not saturated
  output logic                 big_o           // quotient exceeded 32 bits
);
  import cau_pkg::*;

  // Numerator bits followed by FracBits zeros are shifted in, MSB first.
  localparam int unsigned NumW = SumW + FracBits;

  logic [NumW-1:0]  sh_q  [DivSteps+1];
  logic [SumW:0]    rem_q [DivSteps+1];
  logic [SumW-1:0]  den_q [DivSteps+1];
  logic [QuotW-1:0] q_q   [DivSteps+1];
  logic             big_q [DivSteps+1];
  logic             v_q   [DivSteps+1];

  always_comb begin
    sh_q[0]  = {num_i, FracBits'(0)};
    rem_q[0] = '0;
    den_q[0] = den_i;
    q_q[0]   = '0;
    big_q[0] = 1'b0;
    v_q[0]   = valid_i;
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    logic [SumW:0]    rem_d;
    logic [SumW+1:0]  trial;
    logic             bit_d;
    logic [QuotW:0]   q_d;
    always_comb begin
      rem_d = {rem_q[s][SumW-1:0], sh_q[s][NumW-1]};
      trial = {1'b0, rem_d} - {2'b00, den_q[s]};
      bit_d = !trial[SumW+1];
      q_d   = {q_q[s], bit_d};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      sh_q[s+1]  <= sh_q[s] << 1;
      rem_q[s+1] <= bit_d ? trial[SumW:0] : rem_d;
      den_q[s+1] <= den_q[s];
      q_q[s+1]   <= q_d[QuotW-1:0];
      big_q[s+1] <= big_q[s] | q_d[QuotW] | q_d[QuotW-1];
    end
  end

  assign valid_o = v_q[DivSteps];
  assign quot_o  = q_q[DivSteps];
  assign big_o   = big_q[DivSteps];
endmodule

// ===== hdl/complex_arithmetic_unit_core.sv =====
// Top level: pipelined complex add, subtract, multiply and divide in Q16.16.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  command | op_i a_re_i a_im_i b_re_i b_im_i        | start_i, transfer when !busy_o
//  result  | res_re_o res_im_o overflow_o div_zero_o | done_o, one-cycle strobe
//
// Every operation passes through the same pipeline: 3 capture/product/sum stages,
// one restoring-divider stage per quotient bit (81), and one output stage whose
// registers drive done_o and the result together. One command enters every
// cycle; busy_o is never raised. Reset clears only the valid bits. The receiver
// cannot stall.
module complex_arithmetic_unit_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 op_i,
  input  logic signed [31:0]         a_re_i,
  input  logic signed [31:0]         a_im_i,
  input  logic signed [31:0]         b_re_i,
  input  logic signed [31:0]         b_im_i,
  output logic                       done_o,
  output logic signed [31:0]         res_re_o,
  output logic signed [31:0]         res_im_o,
  output logic                       overflow_o,
  output logic                       div_zero_o
);
  import cau_pkg::*;

  localparam int unsigned Lat = DivSteps;

  assign busy_o = 1'b0;

  // Stage 1: capture operands.
  logic              v1_q;
  op_e               op1_q;
  logic signed [DataW-1:0] ar_q, ai_q, br_q, bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    op1_q <= op_e'(op_i);
    ar_q  <= a_re_i;
    ai_q  <= a_im_i;
    br_q  <= b_re_i;
    bi_q  <= b_im_i;
  end

  // Stage 2: six products (cross products and squares of b) and the sums, subtracted for OpSub.
  logic              v2_q;
  op_e               op2_q;
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q, p3_q, d0_q, d1_q;
  logic signed [DataW:0]   sr_q, si_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    op2_q <= op1_q;
    p0_q  <= ar_q * br_q;
    p1_q  <= ai_q * bi_q;
    p2_q  <= ar_q * bi_q;
    p3_q  <= ai_q * br_q;
    d0_q  <= br_q * br_q;
    d1_q  <= bi_q * bi_q;
    if (op1_q == OpSub) begin
      sr_q <= (DataW+1)'(ar_q) - (DataW+1)'(br_q);
      si_q <= (DataW+1)'(ai_q) - (DataW+1)'(bi_q);
    end else begin
      sr_q <= (DataW+1)'(ar_q) + (DataW+1)'(br_q);
      si_q <= (DataW+1)'(ai_q) + (DataW+1)'(bi_q);
    end
  end

  // Stage 3: combine products into real/imag numerators (div uses the conjugate of b) and the denominator.
  logic              v3_q;
  op_e               op3_q;
  logic signed [SumW-1:0] nr_q, ni_q;
  logic [SumW-1:0]        den_q;
  logic signed [DataW:0]  sr3_q, si3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    op3_q <= op2_q;
    sr3_q <= sr_q;
    si3_q <= si_q;
    den_q <= SumW'(d0_q) + SumW'(d1_q);
    if (op2_q == OpDiv) begin
      nr_q <= SumW'(p0_q) + SumW'(p1_q);
      ni_q <= SumW'(p3_q) - SumW'(p2_q);
    end else begin
      nr_q <= SumW'(p0_q) - SumW'(p1_q);
      ni_q <= SumW'(p2_q) + SumW'(p3_q);
    end
  end

  // Sign/magnitude split feeding both dividers.
  smag_t mr, mi;
  assign mr.neg = nr_q[SumW-1];
  assign mr.mag = mr.neg ? SumW'(-nr_q) : SumW'(nr_q);
  assign mi.neg = ni_q[SumW-1];
  assign mi.mag = mi.neg ? SumW'(-ni_q) : SumW'(ni_q);

  // Side line: hold everything the output stage needs alongside the dividers.
  typedef struct packed {
    op_e                  op;
    logic                 zero;
    smag_t                mr;
    smag_t                mi;
    logic [DataW:0]       sr;
    logic [DataW:0]       si;
  } side_t;

  side_t side_q [Lat+1];
  assign side_q[0] = '{op: op3_q, zero: (den_q == '0), mr: mr, mi: mi,
                       sr: sr3_q, si: si3_q};
  for (genvar s = 0; s < Lat; s++) begin : g_side
    always_ff @(posedge clk_i) side_q[s+1] <= side_q[s];
  end

  logic              dv_re, dv_im, big_re, big_im;
  logic [QuotW-1:0]  q_re, q_im;
  logic [SumW-1:0]   den_safe;
  assign den_safe = (den_q == '0) ? SumW'(1) : den_q;

  cau_div u_div_re (
    .clk_i, .rst_ni, .valid_i(v3_q), .num_i(mr.mag), .den_i(den_safe),
    .valid_o(dv_re), .quot_o(q_re), .big_o(big_re)
  );
  cau_div u_div_im (
    .clk_i, .rst_ni, .valid_i(v3_q), .num_i(mi.mag), .den_i(den_safe),
    .valid_o(dv_im), .quot_o(q_im), .big_o(big_im)
  );

  // Output stage: select per op and saturate.
  side_t          sd;
  logic [DataW:0] rr, ri;
  logic [DataW:0] sat_r, sat_i;

  function automatic logic [DataW:0] sat_sum(input logic [DataW:0] v);
    if (v[DataW] != v[DataW-1]) return {1'b1, v[DataW] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    return {1'b0, v[DataW-1:0]};
  endfunction

  always_comb begin
    sd    = side_q[Lat];
    sat_r = '0;
    sat_i = '0;
    case (sd.op)
      OpAdd, OpSub: begin
        sat_r = sat_sum(sd.sr);
        sat_i = sat_sum(sd.si);
      end
      OpMul: begin
        sat_r = sat_mag(sd.mr.neg, sd.mr.mag >> FracBits);
        sat_i = sat_mag(sd.mi.neg, sd.mi.mag >> FracBits);
      end
      default: begin
        if (!sd.zero) begin
          sat_r = sat_mag(sd.mr.neg, big_re ? SumW'(32'hFFFF_FFFF) : SumW'(q_re));
          sat_i = sat_mag(sd.mi.neg, big_im ? SumW'(32'hFFFF_FFFF) : SumW'(q_im));
        end
      end
    endcase
    rr = sat_r;
    ri = sat_i;
  end

  logic done_q, ovf_q, dz_q;
  logic [DataW-1:0] rr_q, ri_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_re;
  end
  always_ff @(posedge clk_i) begin
    rr_q  <= rr[DataW-1:0];
    ri_q  <= ri[DataW-1:0];
    ovf_q <= rr[DataW] | ri[DataW];
    dz_q  <= (sd.op == OpDiv) && sd.zero;
  end

  assign done_o     = done_q;
  assign res_re_o   = rr_q;
  assign res_im_o   = ri_q;
  assign overflow_o = ovf_q;
  assign div_zero_o = dz_q;

`ifndef SYNTHESIS
  a_div_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni) dv_re == dv_im)
    else $error("divider lanes out of step");
  a_dz_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && div_zero_o |-> !overflow_o && res_re_o == '0 && res_im_o == '0)
    else $error("zero divisor gave nonzero result");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
`endif
endmodule
